// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the picture extractor RTL.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/id3pic_pkg.sv =====
// Package for the ID3v2 picture extractor: phases, status codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package id3pic_pkg;
  localparam int PositionBitsDefault = 28;
  localparam logic [27:0] MaxTagReset = 28'd16777216;
  localparam logic [7:0] ExtFlag = 8'h40;
  localparam logic [31:0] ApicId = 32'h41504943;

  typedef enum logic [3:0] {
    PH_HEADER, PH_DEAD, PH_EXT, PH_EXTSKIP, PH_FHDR, PH_FSKIP,
    PH_ENC, PH_MIME, PH_PTYPE, PH_DESC, PH_PIC, PH_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND, ST_NO_HEADER, ST_BAD_SIZE, ST_OLD_VERSION,
    ST_NO_PICTURE, ST_MALFORMED, ST_TRUNCATED
  } status_t;

  // Result beat
  typedef struct packed {
    logic       item_kind;
    logic [7:0] picture_byte;
    logic [2:0] status;
    logic       last_item;
  } result_t;

  function automatic logic [27:0] unsync(input logic [31:0] raw);
    unsync = {raw[30:24], raw[22:16], raw[14:8], raw[6:0]};
  endfunction
endpackage
`default_nettype wire

// ===== hdl/id3pic_if.sv =====
// Valid/ready stream interfaces for input bytes, results and configuration.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface id3pic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;
  modport source (output valid, file_byte, end_of_file, input ready);
  modport sink (input valid, file_byte, end_of_file, output ready);
endinterface

interface id3pic_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] picture_byte;
  logic [2:0] status;
  logic       last_item;
  modport source (output valid, item_kind, picture_byte, status, last_item, input ready);
  modport sink (input valid, item_kind, picture_byte, status, last_item, output ready);
endinterface

interface id3pic_cfg_if;
  logic        valid;
  logic        ready;
  logic [27:0] max_tag_bytes;
  modport source (output valid, max_tag_bytes, input ready);
  modport sink (input valid, max_tag_bytes, output ready);
endinterface
`default_nettype wire

// ===== hdl/id3pic_parser.sv =====
// Per-byte parser: state registers and the single-pass next-state logic.
// Depends on id3pic_pkg; produces up to two result beats per input byte.
`timescale 1ns / 1ps
`default_nettype none
module id3pic_parser #(
  parameter int POSITION_BITS = id3pic_pkg::PositionBitsDefault
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      step,
  input  wire [7:0]                b,
  input  wire                      eof,
  input  wire [27:0]               max_tag,
  output id3pic_pkg::result_t      res0,
  output logic                     res0_valid,
  output id3pic_pkg::result_t      res1,
  output logic                     res1_valid
);
  import id3pic_pkg::*;

  localparam int PW = POSITION_BITS;
  localparam logic [32:0] PosLimit = (33'd1 << PW) - 33'd1;

  phase_t        phase, phase_next;
  logic [PW-1:0] pos, pos_next;
  logic [27:0]   tag_len, tag_len_next;
  logic [7:0]    major, major_next;
  logic [7:0]    flags, flags_next;
  logic [3:0]    shift, shift_next;
  logic [31:0]   fid, fid_next;
  logic [31:0]   flen, flen_next;
  logic [31:0]   frem, frem_next;
  logic [7:0]    enc, enc_next;
  logic [1:0]    pair, pair_next;
  status_t       verdict, verdict_next;

  // Helpers for the frame walk
  logic [32:0] left;
  logic [31:0] w32, w_flen, fsize, ext, frem_dec;
  logic [32:0] fend;
  logic        emit;
  status_t     st;

  always_comb begin
    left = {5'd0, tag_len} - {{(33-PW){1'b0}}, pos_next};
    w32 = {flen[23:0], b};
    w_flen = (shift >= 4'd4 && shift < 4'd8) ? w32 : flen;
    fsize = (major == 8'd4) ? {4'd0, unsync(w_flen)} : w_flen;
    fend = {{(33-PW){1'b0}}, pos_next} + {1'b0, fsize};
    ext = (major == 8'd4) ? {4'd0, unsync(w32)} : w32;
    frem_dec = frem - 32'd1;
  end

  always_comb begin
    phase_next = phase; pos_next = pos; tag_len_next = tag_len;
    major_next = major; flags_next = flags; shift_next = shift;
    fid_next = fid; flen_next = flen; frem_next = frem; enc_next = enc;
    pair_next = pair; verdict_next = verdict; emit = 1'b0; st = verdict;
    if (phase == PH_HEADER) begin
      if ((shift == 4'd0 && b != 8'h49) || (shift == 4'd1 && b != 8'h44) ||
          (shift == 4'd2 && b != 8'h33)) verdict_next = ST_NO_HEADER;
      if (shift == 4'd3) major_next = b;
      if (shift == 4'd5) flags_next = b;
      if (shift >= 4'd6) tag_len_next = {tag_len[20:0], b[6:0]};
      shift_next = shift + 4'd1;
      if (shift == 4'd9) begin
        shift_next = 4'd0;
        if (verdict_next == ST_NO_HEADER) phase_next = PH_DEAD;
        else if (tag_len_next == 28'd0 || tag_len_next > max_tag ||
                 {5'd0, tag_len_next} > PosLimit) begin
          verdict_next = ST_BAD_SIZE; phase_next = PH_DEAD;
        end else begin
          pos_next = '0;
          if ((flags_next & ExtFlag) != 8'd0 && major_next >= 8'd3) begin
            if (tag_len_next < 28'd4) begin
              verdict_next = ST_MALFORMED; phase_next = PH_TAIL;
            end else begin
              phase_next = PH_EXT; flen_next = '0;
            end
          end else if (major_next < 8'd3) begin
            verdict_next = ST_OLD_VERSION; phase_next = PH_TAIL;
          end else if (tag_len_next < 28'd10) begin
            verdict_next = ST_NO_PICTURE; phase_next = PH_TAIL;
          end else begin
            phase_next = PH_FHDR; fid_next = '0; flen_next = '0;
          end
        end
      end
    end else if (phase != PH_DEAD &&
                 {{(33-PW){1'b0}}, pos} < {5'd0, tag_len}) begin
      pos_next = pos + {{(PW-1){1'b0}}, 1'b1};
      case (phase)
        PH_EXT: begin
          flen_next = w32;
          shift_next = shift + 4'd1;
          if (shift == 4'd3) begin
            shift_next = 4'd0;
            if ({1'b0, ext} + 33'd4 >= {5'd0, tag_len}) begin
              verdict_next = ST_MALFORMED; phase_next = PH_TAIL;
            end else if (ext == 32'd0) begin
              if (left < 33'd10) begin
                verdict_next = ST_NO_PICTURE; phase_next = PH_TAIL;
              end else begin
                phase_next = PH_FHDR; fid_next = '0; flen_next = '0;
              end
            end else begin
              frem_next = ext; phase_next = PH_EXTSKIP;
            end
          end
        end
        PH_EXTSKIP, PH_FSKIP: begin
          frem_next = frem_dec;
          if (frem_dec == 32'd0) begin
            if (left < 33'd10) begin
              verdict_next = ST_NO_PICTURE; phase_next = PH_TAIL;
            end else begin
              phase_next = PH_FHDR; shift_next = 4'd0; fid_next = '0; flen_next = '0;
            end
          end
        end
        PH_FHDR: begin
          if (shift < 4'd4) fid_next = {fid[23:0], b};
          else if (shift < 4'd8) flen_next = w32;
          shift_next = shift + 4'd1;
          if (shift == 4'd9) begin
            flen_next = fsize;
            if (fid == 32'd0 || fsize == 32'd0) begin
              verdict_next = ST_NO_PICTURE; phase_next = PH_TAIL;
            end else if (fid == ApicId) begin
              if (fend > {5'd0, tag_len} || fsize < 32'd4) begin
                verdict_next = ST_MALFORMED; phase_next = PH_TAIL;
              end else begin
                frem_next = fsize; phase_next = PH_ENC;
              end
            end else if (fend > {5'd0, tag_len}) begin
              verdict_next = ST_NO_PICTURE; phase_next = PH_TAIL;
            end else begin
              frem_next = fsize; phase_next = PH_FSKIP;
            end
          end
        end
        PH_ENC, PH_MIME, PH_PTYPE, PH_DESC: begin
          frem_next = frem_dec;
          if (phase == PH_ENC) begin
            enc_next = b; phase_next = PH_MIME;
          end else if (phase == PH_MIME) begin
            if (b == 8'd0) phase_next = PH_PTYPE;
          end else if (phase == PH_PTYPE) begin
            phase_next = PH_DESC; pair_next = 2'd0;
          end else if (enc == 8'd0 || enc == 8'd3) begin
            if (b == 8'd0) phase_next = PH_PIC;
          end else if (pair == 2'd0) begin
            pair_next = (b == 8'd0) ? 2'd1 : 2'd2;
          end else begin
            if (pair == 2'd1 && b == 8'd0) phase_next = PH_PIC;
            pair_next = 2'd0;
          end
          if (frem_dec == 32'd0) begin
            verdict_next = ST_MALFORMED; phase_next = PH_TAIL;
          end
        end
        PH_PIC: begin
          frem_next = frem_dec; emit = 1'b1;
          if (frem_dec == 32'd0) begin
            verdict_next = ST_FOUND; phase_next = PH_TAIL;
          end
        end
        default: ;
      endcase
    end
    // Final status on the last file byte
    if (phase_next == PH_HEADER) st = ST_TRUNCATED;
    else if (phase_next == PH_DEAD) st = verdict_next;
    else if ({{(33-PW){1'b0}}, pos_next} < {5'd0, tag_len_next}) st = ST_TRUNCATED;
    else st = verdict_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst || (step && eof)) begin
      phase <= PH_HEADER; pos <= '0; tag_len <= '0; major <= '0; flags <= '0;
      shift <= '0; fid <= '0; flen <= '0; frem <= '0; enc <= '0; pair <= '0;
      verdict <= ST_NO_PICTURE;
    end else if (step) begin
      phase <= phase_next; pos <= pos_next; tag_len <= tag_len_next;
      major <= major_next; flags <= flags_next; shift <= shift_next;
      fid <= fid_next; flen <= flen_next; frem <= frem_next; enc <= enc_next;
      pair <= pair_next; verdict <= verdict_next;
    end
  end

  // Result beats
  always_comb begin
    res0 = '{item_kind: 1'b0, picture_byte: b, status: 3'd0, last_item: 1'b0};
    res1 = '{item_kind: 1'b1, picture_byte: 8'd0, status: st, last_item: 1'b1};
    res0_valid = emit;
    res1_valid = eof;
  end
endmodule
`default_nettype wire

// ===== hdl/id3pic_outq.sv =====
// Four-entry result queue; takes up to two beats per cycle.
// Depends on id3pic_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module id3pic_outq (
  input  wire                 clk,
  input  wire                 rst,
  input  id3pic_pkg::result_t wr0,
  input  wire                 wr0_en,
  input  id3pic_pkg::result_t wr1,
  input  wire                 wr1_en,
  output logic                room,
  output id3pic_pkg::result_t rd,
  output logic                rd_valid,
  input  wire                 rd_ready
);
  import id3pic_pkg::*;

  result_t     mem [4];
  logic [1:0]  wp, rp;
  logic [2:0]  cnt;
  logic        pop;
  logic [1:0]  nwr;

  assign pop = rd_valid && rd_ready;
  assign nwr = {1'b0, wr0_en} + {1'b0, wr1_en};
  assign rd_valid = cnt != 3'd0;
  assign rd = mem[rp];
  // Two free slots even without a pop, so any beat may enter
  assign room = cnt <= 3'd2;

  always_ff @(posedge clk) begin
    if (wr0_en) mem[wp] <= wr0;
    if (wr1_en) mem[wr0_en ? wp + 2'd1 : wp] <= wr1;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + nwr;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {1'b0, nwr} - {2'd0, pop};
    end
  end

  `CHK_IMPL(a_no_overflow, clk, rst, 1'b1, cnt <= 3'd4, "result queue overflow")
  `CHK_IMPL(a_fit, clk, rst, nwr != 2'd0, cnt <= 3'd2, "write without room")
  `CHK_NEXT(a_pop_count, clk, rst, pop && nwr == 2'd0, cnt == $past(cnt) - 3'd1,
    "pop did not lower count")
endmodule
`default_nettype wire

// ===== hdl/id3v2_picture_frame_extractor.sv =====
// ID3v2 embedded picture extractor: one file byte accepted per cycle.
// Result beats of an accepted byte are registered in the result queue before the output.
// Throughput: one byte per cycle; a byte can raise two beats, drained by a
// four-entry result queue, so ready drops only when the consumer stalls.
// Reset (rst, synchronous): parser to header phase, queue empty, limit 16 MiB.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module id3v2_picture_frame_extractor #(
  parameter int POSITION_BITS = id3pic_pkg::PositionBitsDefault
) (
  input wire           clk,
  input wire           rst,
  id3pic_in_if.sink    in_ch,
  id3pic_cfg_if.sink   cfg,
  id3pic_out_if.source out_ch
);
  import id3pic_pkg::*;

  logic [27:0] max_tag;
  logic        room, step, r0v, r1v;
  result_t     r0, r1, rd;

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_tag <= MaxTagReset;
    else if (cfg.valid) max_tag <= cfg.max_tag_bytes;
  end

  assign in_ch.ready = room;
  assign step = in_ch.valid && room;

  id3pic_parser #(.POSITION_BITS(POSITION_BITS)) u_parser (
    .clk, .rst, .step, .b(in_ch.file_byte), .eof(in_ch.end_of_file),
    .max_tag, .res0(r0), .res0_valid(r0v), .res1(r1), .res1_valid(r1v)
  );

  id3pic_outq u_q (
    .clk, .rst, .wr0(r0), .wr0_en(step && r0v), .wr1(r1), .wr1_en(step && r1v),
    .room, .rd, .rd_valid(out_ch.valid), .rd_ready(out_ch.ready)
  );

  assign out_ch.item_kind = rd.item_kind;
  assign out_ch.picture_byte = rd.picture_byte;
  assign out_ch.status = rd.status;
  assign out_ch.last_item = rd.last_item;

  `CHK_IMPL(a_status_last, clk, rst, out_ch.valid, out_ch.item_kind == out_ch.last_item,
    "status beat must be last")
  `CHK_IMPL(a_pic_status, clk, rst, out_ch.valid && !out_ch.item_kind,
    out_ch.status == 3'd0, "picture beat carries status")
endmodule
`default_nettype wire

// ===== verif/id3pic_checker.sv =====
// Scoreboard for the ID3v2 picture extractor: follows the input, config and
// result channels, predicts each result beat and compares it.
// Depends on id3pic_pkg and the stream interfaces in id3pic_if.sv.
`timescale 1ns / 1ps
module id3pic_checker
  import id3pic_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  id3pic_in_if         in_ch,
  id3pic_cfg_if        cfg,
  id3pic_out_if        out_ch,
  output int unsigned  errors,
  output int unsigned  pending
);
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] Ch3 = 8'h33;
  localparam int HdrBytes = 10;

  // Predicted parser state
  logic [27:0] tag_limit;
  phase_t      phase;
  logic [31:0] pos;
  logic [27:0] tag_len;
  logic [7:0]  version;
  logic [7:0]  flags;
  int unsigned idx;
  logic [31:0] fid;
  logic [31:0] flen;
  logic [31:0] frem;
  logic [7:0]  encoding;
  logic [1:0]  pair;
  status_t     verdict;

  result_t expected_beats[$];

  assign pending = expected_beats.size();

  // 7 usable bits per byte of a syncsafe word
  function automatic logic [31:0] desync(input logic [31:0] r);
    return (((r >> 24) & 32'h7F) << 21) | (((r >> 16) & 32'h7F) << 14) |
           (((r >> 8) & 32'h7F) << 7) | (r & 32'h7F);
  endfunction

  function automatic void clear_parse();
    phase = PH_HEADER;
    pos = '0;
    tag_len = '0;
    version = '0;
    flags = '0;
    idx = 0;
    fid = '0;
    flen = '0;
    frem = '0;
    encoding = '0;
    pair = '0;
    verdict = ST_NO_PICTURE;
  endfunction

  function automatic void give_up(input status_t code);
    verdict = code;
    phase = PH_TAIL;
  endfunction

  function automatic void next_frame();
    if ({4'b0, tag_len} - pos < 10) begin
      give_up(ST_NO_PICTURE);
      return;
    end
    phase = PH_FHDR;
    idx = 0;
    fid = '0;
    flen = '0;
  endfunction

  function automatic void close_header();
    if (verdict == ST_NO_HEADER) begin
      phase = PH_DEAD;
      return;
    end
    if (tag_len == 0 || tag_len > tag_limit) begin
      verdict = ST_BAD_SIZE;
      phase = PH_DEAD;
      return;
    end
    pos = '0;
    if ((flags & ExtFlag) != 0 && version >= 3) begin
      if (tag_len < 4) begin
        give_up(ST_MALFORMED);
        return;
      end
      phase = PH_EXT;
      idx = 0;
      flen = '0;
    end else if (version < 3) begin
      give_up(ST_OLD_VERSION);
    end else begin
      next_frame();
    end
  endfunction

  function automatic void close_frame_header();
    logic [31:0] size;
    longint unsigned stop;
    size = (version == 4) ? desync(flen) : flen;
    stop = longint'(pos) + longint'(size);
    flen = size;
    if (fid == 0 || size == 0) begin
      give_up(ST_NO_PICTURE);
    end else if (fid == ApicId) begin
      if (stop > tag_len || size < 4) give_up(ST_MALFORMED);
      else begin
        frem = size;
        phase = PH_ENC;
      end
    end else if (stop > tag_len) begin
      give_up(ST_NO_PICTURE);
    end else begin
      frem = size;
      phase = PH_FSKIP;
    end
  endfunction

  // One byte inside the tag; returns 1 when it is a picture byte
  function automatic bit tag_byte(input logic [7:0] b);
    logic [31:0] ext;
    case (phase)
      PH_EXT: begin
        flen = {flen[23:0], b};
        idx++;
        if (idx == 4) begin
          ext = (version == 4) ? desync(flen) : flen;
          if (longint'(ext) + 4 >= longint'(tag_len)) give_up(ST_MALFORMED);
          else if (ext == 0) next_frame();
          else begin
            frem = ext;
            phase = PH_EXTSKIP;
          end
        end
      end
      PH_EXTSKIP, PH_FSKIP: begin
        frem--;
        if (frem == 0) next_frame();
      end
      PH_FHDR: begin
        if (idx < 4) fid = {fid[23:0], b};
        else if (idx < 8) flen = {flen[23:0], b};
        idx++;
        if (idx == 10) close_frame_header();
      end
      PH_ENC, PH_MIME, PH_PTYPE, PH_DESC: begin
        frem--;
        if (phase == PH_ENC) begin
          encoding = b;
          phase = PH_MIME;
        end else if (phase == PH_MIME) begin
          if (b == 0) phase = PH_PTYPE;
        end else if (phase == PH_PTYPE) begin
          phase = PH_DESC;
          pair = 0;
        end else if (encoding == 0 || encoding == 3) begin
          if (b == 0) phase = PH_PIC;
        end else if (pair == 0) begin
          pair = (b == 0) ? 2'd1 : 2'd2;
        end else begin
          // aligned double zero ends a wide description
          if (pair == 1 && b == 0) phase = PH_PIC;
          pair = 0;
        end
        if (frem == 0) give_up(ST_MALFORMED);
      end
      PH_PIC: begin
        frem--;
        if (frem == 0) begin
          verdict = ST_FOUND;
          phase = PH_TAIL;
        end
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic eof);
    result_t beat;
    status_t st;
    if (phase == PH_HEADER) begin
      if ((idx == 0 && b != ChI) || (idx == 1 && b != ChD) || (idx == 2 && b != Ch3))
        verdict = ST_NO_HEADER;
      if (idx == 3) version = b;
      if (idx == 5) flags = b;
      if (idx >= 6) tag_len = {tag_len[20:0], b[6:0]};
      idx++;
      if (idx >= HdrBytes) begin
        idx = 0;
        close_header();
      end
    end else if (phase != PH_DEAD && pos < tag_len) begin
      pos++;
      if (tag_byte(b)) begin
        beat = '{item_kind: 1'b0, picture_byte: b, status: 3'd0, last_item: 1'b0};
        expected_beats.push_back(beat);
      end
    end
    if (eof) begin
      if (phase == PH_HEADER) st = ST_TRUNCATED;
      else if (phase == PH_DEAD) st = verdict;
      else if (pos < tag_len) st = ST_TRUNCATED;
      else st = verdict;
      beat = '{item_kind: 1'b1, picture_byte: 8'd0, status: st, last_item: 1'b1};
      expected_beats.push_back(beat);
      clear_parse();
    end
  endfunction

  // Watch all channels at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      tag_limit = MaxTagReset;
      clear_parse();
      expected_beats.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) tag_limit = cfg.max_tag_bytes;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind=%0d byte=%h status=%0d last=%0d", $time,
                   out_ch.item_kind, out_ch.picture_byte, out_ch.status, out_ch.last_item);
        end else begin
          want = expected_beats.pop_front();
          if (want.item_kind !== out_ch.item_kind || want.picture_byte !== out_ch.picture_byte ||
              want.status !== out_ch.status || want.last_item !== out_ch.last_item) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d byte=%h status=%0d last=%0d", $time,
                     want.item_kind, want.picture_byte, want.status, want.last_item);
            $display("%0t:          actual   kind=%0d byte=%h status=%0d last=%0d", $time,
                     out_ch.item_kind, out_ch.picture_byte, out_ch.status, out_ch.last_item);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) take_byte(in_ch.file_byte, in_ch.end_of_file);
    end
  end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the ID3v2 picture extractor: clock, reset, file stimulus
// with random idling, config writes and the verdict.
// Depends on id3pic_pkg, id3pic_if.sv, the extractor RTL and id3pic_checker.
`timescale 1ns / 1ps
module tb;
  import id3pic_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int NumPhases = 5;
  localparam int HoldCycles = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned src_idle = 0;
  int unsigned sink_idle = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;
  logic [7:0] file_bytes[$];

  id3pic_in_if  in_ch ();
  id3pic_cfg_if cfg_ch ();
  id3pic_out_if out_ch ();

  id3v2_picture_frame_extractor dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg_ch), .out_ch(out_ch)
  );

  id3pic_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle);
    end
  end

  task automatic put32(ref logic [7:0] q[$], input logic [31:0] v, input bit syncsafe);
    logic [31:0] w;
    w = syncsafe ? {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]} : v;
    for (int i = 3; i >= 0; i--) q.push_back(w[8*i +: 8]);
  endtask

  task automatic put_frame(ref logic [7:0] q[$], input logic [31:0] id,
                           ref logic [7:0] content[$], input bit v4);
    put32(q, id, 1'b0);
    put32(q, content.size(), v4);
    q.push_back($urandom_range(255));
    q.push_back($urandom_range(255));
    foreach (content[i]) q.push_back(content[i]);
  endtask

  // Picture frame content: encoding, MIME, picture type, description, data
  task automatic picture_content(ref logic [7:0] c[$]);
    logic [7:0] enc;
    int n;
    enc = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    c.push_back(enc);
    n = $urandom_range(0, 5);
    repeat (n) c.push_back($urandom_range(1, 255));
    c.push_back(8'h00);
    c.push_back($urandom_range(255));
    n = $urandom_range(0, 4);
    if (enc == 0 || enc == 3) begin
      repeat (n) c.push_back($urandom_range(1, 255));
      c.push_back(8'h00);
    end else begin
      repeat (n) begin
        c.push_back($urandom_range(1, 255));
        c.push_back($urandom_range(255));
      end
      c.push_back(8'h00);
      c.push_back(8'h00);
    end
    n = $urandom_range(1, 20);
    repeat (n) c.push_back($urandom_range(255));
  endtask

  task automatic build_file();
    logic [7:0] body[$];
    logic [7:0] c[$];
    logic [7:0] ver;
    logic [31:0] id;
    logic [27:0] tag;
    bit ext, v4;
    int n, pic_at, cut;
    file_bytes.delete();
    // noise, occasionally
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 30);
      repeat (n) file_bytes.push_back($urandom_range(255));
      if ($urandom_range(1)) begin
        file_bytes[0] = "I";
        if (n > 1) file_bytes[1] = "D";
        if (n > 2) file_bytes[2] = "3";
      end
      return;
    end
    n = $urandom_range(9);
    ver = (n == 0) ? 8'($urandom_range(0, 2)) : (n < 5) ? 8'd3 : (n == 9) ?
          8'($urandom_range(5, 255)) : 8'd4;
    v4 = (ver == 4);
    ext = ($urandom_range(4) == 0);
    if (ext) begin
      n = $urandom_range(0, 6);
      put32(body, n, v4);
      repeat (n) body.push_back($urandom_range(255));
    end
    n = $urandom_range(0, 3);
    pic_at = ($urandom_range(4) == 0) ? -1 : $urandom_range(0, n);
    for (int f = 0; f <= n; f++) begin
      c.delete();
      if (f == pic_at) begin
        picture_content(c);
        id = ApicId;
      end else begin
        repeat ($urandom_range(1, 8)) c.push_back($urandom_range(255));
        id = {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
              8'($urandom_range(48, 90)), 8'($urandom_range(48, 90))};
      end
      put_frame(body, id, c, v4);
    end
    repeat ($urandom_range(0, 12)) body.push_back(8'h00);
    tag = body.size();
    file_bytes = '{"I", "D", "3"};
    file_bytes.push_back(ver);
    file_bytes.push_back($urandom_range(255));
    file_bytes.push_back((ext ? ExtFlag : 8'h00) | (8'($urandom_range(255)) & 8'h3F));
    put32(file_bytes, tag, 1'b1);
    // syncsafe size bytes ignore their top bit
    if ($urandom_range(5) == 0)
      for (int i = 6; i < 10; i++) file_bytes[i][7] = $urandom_range(1);
    foreach (body[i]) file_bytes.push_back(body[i]);
    repeat ($urandom_range(0, 4)) file_bytes.push_back($urandom_range(255));
    n = $urandom_range(9);
    if (n == 0) begin
      cut = $urandom_range(1, file_bytes.size() - 1);
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end else if (n == 1) begin
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = $urandom_range(255);
    end
  endtask

  // Called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.file_byte <= b;
    in_ch.end_of_file <= eof;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  task automatic write_limit(input logic [27:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_tag_bytes <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [27:0] limits[NumPhases];
    int unsigned budget[NumPhases];
    int unsigned srcs[NumPhases];
    int unsigned sinks[NumPhases];
    int unsigned sent;
    bit paused;
    in_ch.valid = 1'b0;
    in_ch.file_byte = '0;
    in_ch.end_of_file = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_tag_bytes = '0;
    out_ch.ready = 1'b0;
    limits = '{28'hFFFFFFF, 28'($urandom_range(20, 120)), 28'd1, MaxTagReset,
               28'($urandom_range(60, 300))};
    budget = '{400, 420, 120, 350, 360};
    srcs = '{0, 65, 19, 0, 19};
    sinks = '{0, 0, 19, 65, 19};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: short files, bad magic, zero size, old version, limits at reset
    file_bytes = '{8'hFF};
    send_file();
    file_bytes = '{8'h00, 8'h44, 8'h33};
    send_file();
    file_bytes = '{"I", "D", "3", 8'd4, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA};
    send_file();
    file_bytes = '{"I", "D", "3", 8'd2, 8'd0, 8'h40, 8'h80, 8'h80, 8'h80, 8'h81, 8'h55};
    send_file();

    for (int p = 0; p < NumPhases; p++) begin
      quiesce();
      write_limit(limits[p]);
      src_idle = srcs[p];
      sink_idle = sinks[p];
      if (p == 0) hold_req = 1'b1;
      sent = 0;
      paused = 1'b0;
      while (sent < budget[p]) begin
        build_file();
        if (!paused && sent > budget[p] / 2) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        send_file();
        sent += file_bytes.size();
      end
    end

    in_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
